### rtl/core/sttab_pkg.sv
package sttab_pkg;

   // Field widths of the request and response beats.
   localparam int KIND_W    = 3;
   localparam int TIME_W    = 11;
   localparam int STATE_W   = 2;
   localparam int PAYLOAD_W = 16;
   localparam int COUNT_W   = 5;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd4;

   // Entry state codes.
   localparam logic [STATE_W-1:0] ST_ENABLED  = 2'd0;
   localparam logic [STATE_W-1:0] ST_NEXT_OFF = 2'd2;
   localparam logic [STATE_W-1:0] ST_INVALID  = 2'd3;

   localparam logic [TIME_W-1:0] LAST_MINUTE = 11'd1439;

   // Datapath actions issued by the controller.
   localparam logic [4:0] ACT_NONE      = 5'd0;
   localparam logic [4:0] ACT_CAPTURE   = 5'd1;
   localparam logic [4:0] ACT_SCAN_READ = 5'd2;
   localparam logic [4:0] ACT_SCAN_NEXT = 5'd3;
   localparam logic [4:0] ACT_INS_PREP  = 5'd4;
   localparam logic [4:0] ACT_INS_READ  = 5'd5;
   localparam logic [4:0] ACT_INS_WRITE = 5'd6;
   localparam logic [4:0] ACT_INS_PUT   = 5'd7;
   localparam logic [4:0] ACT_REM_PREP  = 5'd8;
   localparam logic [4:0] ACT_REM_READ  = 5'd9;
   localparam logic [4:0] ACT_REM_WRITE = 5'd10;
   localparam logic [4:0] ACT_REM_DONE  = 5'd11;
   localparam logic [4:0] ACT_SET_WRITE = 5'd12;
   localparam logic [4:0] ACT_CUR_PREP  = 5'd13;
   localparam logic [4:0] ACT_CUR_READ  = 5'd14;
   localparam logic [4:0] ACT_DIS_READ  = 5'd15;
   localparam logic [4:0] ACT_DIS_WRITE = 5'd16;

   // How the outcome of the operation is recorded.
   localparam logic [2:0] RES_NONE  = 3'd0;
   localparam logic [2:0] RES_FAIL  = 3'd1;
   localparam logic [2:0] RES_OK    = 3'd2;
   localparam logic [2:0] RES_ENTRY = 3'd3;
   localparam logic [2:0] RES_NEXT  = 3'd4;

   typedef struct packed {
      logic [4:0] action;
      logic [2:0] res;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              bad;
      logic              empty;
      logic              scan_end;
      logic              scan_stop;
      logic              hit;
      logic              at_pos;
      logic              rem_end;
      logic              steps_done;
      logic              enabled;
   } stat_type;

endpackage

### rtl/core/sttab_ctrl.sv
module sttab_ctrl
   import sttab_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_SCAN_RD  = 4'd2;
   localparam logic [3:0] S_SCAN_CMP = 4'd3;
   localparam logic [3:0] S_DECIDE   = 4'd4;
   localparam logic [3:0] S_INS_RD   = 4'd5;
   localparam logic [3:0] S_INS_WR   = 4'd6;
   localparam logic [3:0] S_REM_RD   = 4'd7;
   localparam logic [3:0] S_REM_WR   = 4'd8;
   localparam logic [3:0] S_QRY_RD   = 4'd9;
   localparam logic [3:0] S_DIS_RD   = 4'd10;
   localparam logic [3:0] S_DIS_CMP  = 4'd11;
   localparam logic [3:0] S_FINISH   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.action   = ACT_NONE;
      cmd.res      = RES_NONE;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.action = ACT_CAPTURE;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.bad || (stat.empty && stat.kind != KIND_INSERT)) begin
               cmd.res  = RES_FAIL;
               state_in = S_FINISH;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               state_in = S_DECIDE;
            end else begin
               cmd.action = ACT_SCAN_READ;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (stat.scan_stop) begin
               state_in = S_DECIDE;
            end else begin
               cmd.action = ACT_SCAN_NEXT;
               state_in   = S_SCAN_RD;
            end
         end
         S_DECIDE: begin
            unique case (stat.kind)
               KIND_INSERT: begin
                  if (stat.hit) begin
                     cmd.res  = RES_OK;
                     state_in = S_FINISH;
                  end else begin
                     cmd.action = ACT_INS_PREP;
                     state_in   = S_INS_RD;
                  end
               end
               KIND_REMOVE: begin
                  if (stat.hit) begin
                     cmd.action = ACT_REM_PREP;
                     state_in   = S_REM_RD;
                  end else begin
                     cmd.res  = RES_FAIL;
                     state_in = S_FINISH;
                  end
               end
               KIND_SET: begin
                  if (stat.hit) begin
                     cmd.action = ACT_SET_WRITE;
                     cmd.res    = RES_OK;
                  end else begin
                     cmd.res = RES_FAIL;
                  end
                  state_in = S_FINISH;
               end
               KIND_QUERY: begin
                  cmd.action = ACT_CUR_PREP;
                  state_in   = S_QRY_RD;
               end
               KIND_DISABLE: begin
                  cmd.action = ACT_CUR_PREP;
                  state_in   = S_DIS_RD;
               end
               default: begin
                  cmd.res  = RES_FAIL;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_INS_RD: begin
            if (stat.at_pos) begin
               cmd.action = ACT_INS_PUT;
               cmd.res    = RES_OK;
               state_in   = S_FINISH;
            end else begin
               cmd.action = ACT_INS_READ;
               state_in   = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.action = ACT_INS_WRITE;
            state_in   = S_INS_RD;
         end
         S_REM_RD: begin
            if (stat.rem_end) begin
               cmd.action = ACT_REM_DONE;
               cmd.res    = RES_OK;
               state_in   = S_FINISH;
            end else begin
               cmd.action = ACT_REM_READ;
               state_in   = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.action = ACT_REM_WRITE;
            state_in   = S_REM_RD;
         end
         S_QRY_RD: begin
            // The entry lands in the read register at the same edge.
            cmd.action = ACT_CUR_READ;
            cmd.res    = RES_ENTRY;
            state_in   = S_FINISH;
         end
         S_DIS_RD: begin
            if (stat.steps_done) begin
               cmd.res  = RES_FAIL;
               state_in = S_FINISH;
            end else begin
               cmd.action = ACT_DIS_READ;
               state_in   = S_DIS_CMP;
            end
         end
         S_DIS_CMP: begin
            if (stat.enabled) begin
               cmd.action = ACT_DIS_WRITE;
               cmd.res    = RES_NEXT;
               state_in   = S_FINISH;
            end else begin
               state_in = S_DIS_RD;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/sttab_dpath.sv
module sttab_dpath
   import sttab_pkg::*;
#(
   parameter int MAX_ENTRIES  = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [TIME_W-1:0]    req_time_minutes,
   input  logic [STATE_W-1:0]   req_new_state,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  cmd_type              cmd,
   output stat_type             stat,
   output logic                 rsp_ok,
   output logic [TIME_W-1:0]    rsp_entry_time,
   output logic [STATE_W-1:0]   rsp_entry_state,
   output logic [PAYLOAD_W-1:0] rsp_entry_payload,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   localparam int IW  = $clog2(MAX_ENTRIES);
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int CW1 = CW + 1;
   localparam int PW  = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
   localparam int EW  = TIME_W + STATE_W + PW;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   logic [EW-1:0] slot_mem [MAX_ENTRIES];

   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [TIME_W-1:0]  tm_ff, tm_in;
   logic [STATE_W-1:0] nst_ff, nst_in;
   logic [PW-1:0]      pay_ff, pay_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      steps_ff, steps_in;
   logic [EW-1:0]      rd_data_ff;
   logic               ok_ff, ok_in;
   logic               give_ff, give_in;
   logic               next_ff, next_in;

   logic                 rsp_ok_ff;
   logic [TIME_W-1:0]    rsp_time_ff;
   logic [STATE_W-1:0]   rsp_state_ff;
   logic [PAYLOAD_W-1:0] rsp_payload_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic [EW-1:0]      wr_data;
   logic [TIME_W-1:0]  rd_tm;
   logic [STATE_W-1:0] rd_st;
   logic [PW-1:0]      rd_pay;
   logic [CW-1:0]      ptr_inc, ptr_wrap, cur_idx;
   logic               pred_scan;

   assign rd_tm  = rd_data_ff[EW-1 -: TIME_W];
   assign rd_st  = rd_data_ff[PW +: STATE_W];
   assign rd_pay = rd_data_ff[PW-1:0];

   assign ptr_inc  = ptr_ff + CNT_ONE;
   assign ptr_wrap = (ptr_inc < count_ff) ? ptr_inc : '0;
   // The current entry is the one before the first later entry, or the last one.
   assign cur_idx  = (idx_ff == '0) ? (count_ff - CNT_ONE) : (idx_ff - CNT_ONE);
   assign pred_scan = (kind_ff == KIND_QUERY) || (kind_ff == KIND_DISABLE);

   always_comb begin
      stat.kind      = kind_ff;
      stat.bad       = (kind_ff > KIND_DISABLE)
                    || ((kind_ff == KIND_INSERT)
                        && ((tm_ff > LAST_MINUTE) || (nst_ff == ST_INVALID)
                            || (count_ff == CNT_MAX)))
                    || ((kind_ff == KIND_SET) && (nst_ff == ST_INVALID));
      stat.empty      = (count_ff == '0);
      stat.scan_end   = (idx_ff == count_ff);
      stat.scan_stop  = pred_scan ? (rd_tm > tm_ff) : (rd_tm >= tm_ff);
      stat.hit        = (idx_ff != count_ff) && (rd_tm == tm_ff);
      stat.at_pos     = (ptr_ff == idx_ff);
      stat.rem_end    = (CW1'(ptr_ff) + CW1'(1)) >= CW1'(count_ff);
      stat.steps_done = (steps_ff == count_ff);
      stat.enabled    = (rd_st == ST_ENABLED);
   end

   always_comb begin
      kind_in  = kind_ff;
      tm_in    = tm_ff;
      nst_in   = nst_ff;
      pay_in   = pay_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      steps_in = steps_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      unique case (cmd.action)
         ACT_NONE: begin
         end
         ACT_CAPTURE: begin
            kind_in = req_kind;
            tm_in   = req_time_minutes;
            nst_in  = req_new_state;
            pay_in  = req_payload[PW-1:0];
            idx_in  = '0;
         end
         ACT_SCAN_READ: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff[IW-1:0];
         end
         ACT_SCAN_NEXT: begin
            idx_in = idx_ff + CNT_ONE;
         end
         ACT_INS_PREP: begin
            ptr_in = count_ff;
         end
         ACT_INS_READ: begin
            rd_en   = 1'b1;
            rd_addr = IW'(ptr_ff - CNT_ONE);
         end
         ACT_INS_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[IW-1:0];
            wr_data = rd_data_ff;
            ptr_in  = ptr_ff - CNT_ONE;
         end
         ACT_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IW-1:0];
            wr_data  = {tm_ff, nst_ff, pay_ff};
            count_in = count_ff + CNT_ONE;
         end
         ACT_REM_PREP: begin
            ptr_in = idx_ff;
         end
         ACT_REM_READ: begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc[IW-1:0];
         end
         ACT_REM_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[IW-1:0];
            wr_data = rd_data_ff;
            ptr_in  = ptr_inc;
         end
         ACT_REM_DONE: begin
            count_in = count_ff - CNT_ONE;
         end
         ACT_SET_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = {tm_ff, nst_ff, rd_pay};
         end
         ACT_CUR_PREP: begin
            ptr_in   = cur_idx;
            steps_in = '0;
         end
         ACT_CUR_READ: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff[IW-1:0];
         end
         ACT_DIS_READ: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_wrap[IW-1:0];
            ptr_in   = ptr_wrap;
            steps_in = steps_ff + CNT_ONE;
         end
         ACT_DIS_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[IW-1:0];
            wr_data = {rd_tm, ST_NEXT_OFF, rd_pay};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ok_in   = ok_ff;
      give_in = give_ff;
      next_in = next_ff;
      unique case (cmd.res)
         RES_NONE: begin
         end
         RES_FAIL: begin
            ok_in   = 1'b0;
            give_in = 1'b0;
            next_in = 1'b0;
         end
         RES_OK: begin
            ok_in   = 1'b1;
            give_in = 1'b0;
            next_in = 1'b0;
         end
         RES_ENTRY: begin
            ok_in   = 1'b1;
            give_in = 1'b1;
            next_in = 1'b0;
         end
         RES_NEXT: begin
            ok_in   = 1'b1;
            give_in = 1'b1;
            next_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      tm_ff    <= tm_in;
      nst_ff   <= nst_in;
      pay_ff   <= pay_in;
      idx_ff   <= idx_in;
      ptr_ff   <= ptr_in;
      steps_ff <= steps_in;
      ok_ff    <= ok_in;
      give_ff  <= give_in;
      next_ff  <= next_in;
      if (cmd.out_load) begin
         rsp_ok_ff      <= ok_ff;
         rsp_time_ff    <= give_ff ? rd_tm : '0;
         rsp_state_ff   <= give_ff ? (next_ff ? ST_NEXT_OFF : rd_st) : '0;
         rsp_payload_ff <= give_ff ? PAYLOAD_W'(rd_pay) : '0;
         rsp_count_ff   <= COUNT_W'(count_ff);
      end
   end

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_entry_time    = rsp_time_ff;
   assign rsp_entry_state   = rsp_state_ff;
   assign rsp_entry_payload = rsp_payload_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

### rtl/core/sorted_time_slot_table_core.sv
// Channel   Handshake               Beat contents
// request   req_valid / req_ready   req_kind, req_time_minutes, req_new_state, req_payload
// response  rsp_valid / rsp_ready   rsp_ok, rsp_entry_time, rsp_entry_state,
//                                   rsp_entry_payload, rsp_entry_count
//
// One request is handled at a time, and the next is taken in the cycle after its response is
// loaded. The time a request takes grows with S, the number of entries scanned in order, and
// M, the number shifted (insert, remove) or visited by the circular disable-next scan; each
// entry goes through the registered table read. Reset is synchronous and empties the table at
// once; the memory is not cleared. A stalled response only holds off the completion of the next
// request.
module sorted_time_slot_table_core
   import sttab_pkg::*;
#(
   parameter int MAX_ENTRIES  = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [TIME_W-1:0]    req_time_minutes,
   input  logic [STATE_W-1:0]   req_new_state,
   input  logic [PAYLOAD_W-1:0] req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [TIME_W-1:0]    rsp_entry_time,
   output logic [STATE_W-1:0]   rsp_entry_state,
   output logic [PAYLOAD_W-1:0] rsp_entry_payload,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   cmd_type  cmd;
   stat_type stat;

   sttab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sttab_dpath #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_kind          (req_kind),
      .req_time_minutes  (req_time_minutes),
      .req_new_state     (req_new_state),
      .req_payload       (req_payload),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ok            (rsp_ok),
      .rsp_entry_time    (rsp_entry_time),
      .rsp_entry_state   (rsp_entry_state),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule
